[design/utx_pkg.sv]
// shared types and constants for the uart transmitter with fifo
// no dependencies; imported by every module of the block
`default_nettype none

package utx_pkg;

  // input kind codes
  localparam logic KIND_PUSH = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_BITS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STOP_LEN  = 1'd1;

  // configuration reset values
  localparam logic [3:0] DATA_BITS_RST = 4'd8;
  localparam logic [1:0] STOP_LEN_RST  = 2'd1;

  // bit position marking the load phase
  localparam logic [7:0] POS_LOAD = 8'hff;

  // classified item passed from the front end to the engine
  typedef struct packed {
    logic       tick;
    logic [7:0] data;
  } cmd_t;

endpackage

`default_nettype wire

[design/uart_tx_fifo_serializer.sv]
// top level of the uart transmitter with fifo
// depends on utx_pkg, utx_front, utx_cmdq, utx_back
//
// Usage: each input item is either a push (in_kind = 0, in_byte_in queued
// into a FIFO_DEPTH-slot byte fifo, one slot kept free) or a bit-time tick
// (in_kind = 1). Every item gives exactly one result item: the serial line
// level, the busy flag and a dropped flag for a push that found the fifo full.
// Items move on valid high and stall low at a rising edge on either channel.
// From input accept to the result being presented, an item passes the
// input register loaded at the accept edge, the two-entry command queue
// and the engine with its output register.
// Throughput is one item per clock while out_stall is low; the engine
// updates its state, fifo memory write port and registered read port once per cycle.
// The cfg port writes data_bits (index 0) and the stop length (index 1);
// write it only while the block holds no items.
// Reset: synchronous, active low; fifo empty, transmitter idle, line high,
// data_bits 8, stop length 1. No clearing pass is needed.
// A stalled receiver holds the result in the output register; the queue keeps
// filling behind it, then in_stall rises.
`default_nettype none

module uart_tx_fifo_serializer import utx_pkg::*; #(
  parameter int FIFO_DEPTH = 64
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic                  in_kind,
  input  wire logic [7:0]            in_byte_in,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic                       out_tx_line,
  output logic                       out_busy_res,
  output logic                       out_dropped
);

  logic f_valid;
  cmd_t f_cmd;
  logic q_ready;
  logic q_valid;
  cmd_t q_cmd;
  logic q_pop;

  // front end: accept and classify
  utx_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_kind    (in_kind),
    .in_byte_in (in_byte_in),
    .cmd_valid  (f_valid),
    .cmd        (f_cmd),
    .cmd_ready  (q_ready)
  );

  // decoupling queue
  utx_cmdq u_cmdq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_data  (f_cmd),
    .push_ready (q_ready),
    .pop_valid  (q_valid),
    .pop_data   (q_cmd),
    .pop        (q_pop)
  );

  // back end: fifo and serializer
  utx_back #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .cmd_valid    (q_valid),
    .cmd          (q_cmd),
    .cmd_pop      (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_tx_line  (out_tx_line),
    .out_busy_res (out_busy_res),
    .out_dropped  (out_dropped)
  );

endmodule

`default_nettype wire

[design/utx_front.sv]
// input stage: accepts items, classifies them into commands
// depends on utx_pkg
`default_nettype none

module utx_front import utx_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic       in_kind,
  input  wire logic [7:0] in_byte_in,
  output logic            cmd_valid,
  output cmd_t            cmd,
  input  wire logic       cmd_ready
);

  logic valid_r, valid_nxt;
  cmd_t cmd_r, cmd_nxt;
  logic load;

  // stall only while the held command cannot move on
  assign in_stall = valid_r && !cmd_ready;
  assign load     = in_valid && !in_stall;

  // classify the item; a tick carries no byte
  always_comb begin
    valid_nxt = valid_r;
    cmd_nxt   = cmd_r;
    if (load) begin
      valid_nxt    = 1'b1;
      cmd_nxt.tick = (in_kind == KIND_TICK);
      cmd_nxt.data = (in_kind == KIND_TICK) ? 8'd0 : in_byte_in;
    end else if (cmd_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
  end

  assign cmd_valid = valid_r;
  assign cmd       = cmd_r;

endmodule

`default_nettype wire

[design/utx_cmdq.sv]
// two-entry command queue between front end and engine
// depends on utx_pkg
`default_nettype none

module utx_cmdq import utx_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push_valid,
  input  wire cmd_t push_data,
  output logic      push_ready,
  output logic      pop_valid,
  output cmd_t      pop_data,
  input  wire logic pop
);

  cmd_t       q_r [2];
  logic       wr_idx_r, wr_idx_nxt;
  logic       rd_idx_r, rd_idx_nxt;
  logic [1:0] count_r, count_nxt;
  logic       push;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_data   = q_r[rd_idx_r];
  assign push       = push_valid && push_ready;

  // pointer and occupancy update
  always_comb begin
    wr_idx_nxt = push ? ~wr_idx_r : wr_idx_r;
    rd_idx_nxt = pop ? ~rd_idx_r : rd_idx_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_idx_r <= 1'b0;
      rd_idx_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_idx_r <= wr_idx_nxt;
      rd_idx_r <= rd_idx_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_idx_r] <= push_data;
    end
  end

  // checks
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= 2'd2)
    else $error("command queue count out of range");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> count_r != 2'd0)
    else $error("engine popped an empty command queue");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == 2'd0 || count_r == 2'd2) |-> wr_idx_r == rd_idx_r)
    else $error("command queue pointers disagree with count");

endmodule

`default_nettype wire

[design/utx_back.sv]
// transmit engine: byte fifo memory, serializer state and output register
// depends on utx_pkg
`default_nettype none

module utx_back import utx_pkg::*; #(
  parameter int FIFO_DEPTH = 64
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                  cmd_valid,
  input  wire cmd_t                  cmd,
  output logic                       cmd_pop,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic                       out_tx_line,
  output logic                       out_busy_res,
  output logic                       out_dropped
);

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(FIFO_DEPTH - 1);

  function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
    return (p == LAST) ? '0 : p + PTR_W'(1);
  endfunction

  // configuration
  logic [3:0] data_bits_r, data_bits_nxt;
  logic [1:0] stop_len_r, stop_len_nxt;

  // serializer state
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic             active_r, active_nxt;
  logic [7:0]       pos_r, pos_nxt;
  logic [7:0]       shift_r, shift_nxt;
  logic             line_r, line_nxt;

  // fifo memory with registered read and write-through bypass
  logic [7:0] mem [FIFO_DEPTH];
  logic [7:0] rdata_r;
  logic       byp_r, byp_nxt;
  logic [7:0] byp_data_r;
  logic [7:0] head;
  logic       wr_en;

  // output register
  logic out_valid_r, out_valid_nxt;
  logic out_line_r, out_busy_r, out_drop_r;

  logic       exec;
  logic       drop;
  logic [8:0] pos_ext;
  logic [8:0] hi_lo, hi_hi, end_lim;
  logic [7:0] k;

  assign exec    = cmd_valid && (!out_valid_r || !out_stall);
  assign cmd_pop = exec;
  assign head    = byp_r ? byp_data_r : rdata_r;

  // configuration writes
  always_comb begin
    data_bits_nxt = data_bits_r;
    stop_len_nxt  = stop_len_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_DATA_BITS: data_bits_nxt = cfg_wdata;
        CFG_STOP_LEN:  stop_len_nxt  = cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  // position bounds for the current character
  assign pos_ext = {1'b0, pos_r};
  assign hi_lo   = 9'(data_bits_r) + 9'd1;
  assign hi_hi   = 9'(data_bits_r) + 9'd4;
  assign end_lim = 9'(data_bits_r) + 9'(stop_len_r);
  assign k       = pos_r - 8'd1;

  // execute one command
  always_comb begin
    rd_ptr_nxt = rd_ptr_r;
    wr_ptr_nxt = wr_ptr_r;
    active_nxt = active_r;
    pos_nxt    = pos_r;
    shift_nxt  = shift_r;
    line_nxt   = line_r;
    wr_en      = 1'b0;
    drop       = 1'b0;
    if (exec) begin
      if (!cmd.tick) begin
        // push: store unless full, arm an idle transmitter
        if (rd_ptr_r != next_slot(wr_ptr_r)) begin
          wr_en      = 1'b1;
          wr_ptr_nxt = next_slot(wr_ptr_r);
        end else begin
          drop = 1'b1;
        end
        if (!active_r) begin
          active_nxt = 1'b1;
          pos_nxt    = POS_LOAD;
        end
      end else if (active_r) begin
        // line level for this bit time
        if (pos_r == 8'd0) begin
          line_nxt = 1'b0;
        end else if (pos_ext >= hi_lo && pos_ext <= hi_hi) begin
          line_nxt = 1'b1;
        end else if (pos_r != POS_LOAD) begin
          line_nxt = (k < 8'd8) ? shift_r[k[2:0]] : 1'b0;
        end
        // end of character: load next byte or go idle
        if (pos_ext > end_lim) begin
          if (rd_ptr_r != wr_ptr_r) begin
            shift_nxt  = head;
            rd_ptr_nxt = next_slot(rd_ptr_r);
          end else begin
            active_nxt = 1'b0;
          end
          pos_nxt = 8'd0;
        end else begin
          pos_nxt = pos_r + 8'd1;
        end
      end
    end
  end

  // a write landing on the next read address is forwarded
  assign byp_nxt = wr_en && (wr_ptr_r == rd_ptr_nxt);

  // output register holds a result until taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (exec) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_bits_r <= DATA_BITS_RST;
      stop_len_r  <= STOP_LEN_RST;
      rd_ptr_r    <= '0;
      wr_ptr_r    <= '0;
      active_r    <= 1'b0;
      pos_r       <= 8'd0;
      shift_r     <= 8'd0;
      line_r      <= 1'b1;
      byp_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      data_bits_r <= data_bits_nxt;
      stop_len_r  <= stop_len_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      wr_ptr_r    <= wr_ptr_nxt;
      active_r    <= active_nxt;
      pos_r       <= pos_nxt;
      shift_r     <= shift_nxt;
      line_r      <= line_nxt;
      byp_r       <= byp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // fifo memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr_r] <= cmd.data;
    end
    rdata_r    <= mem[rd_ptr_nxt];
    byp_data_r <= cmd.data;
  end

  // result payload
  always_ff @(posedge clk) begin
    if (exec) begin
      out_line_r <= line_nxt;
      out_busy_r <= active_nxt;
      out_drop_r <= drop;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_tx_line  = out_line_r;
  assign out_busy_res = out_busy_r;
  assign out_dropped  = out_drop_r;

  // checks
  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    rd_ptr_r <= LAST && wr_ptr_r <= LAST)
    else $error("fifo pointer beyond depth");

  a_idle_pos: assert property (@(posedge clk) disable iff (!rst_n)
    !active_r |-> pos_r == 8'd0)
    else $error("idle transmitter with nonzero bit position");

  a_arm: assert property (@(posedge clk) disable iff (!rst_n)
    (exec && !cmd.tick && !active_r) |=> (active_r && pos_r == POS_LOAD))
    else $error("push did not arm the idle transmitter");

  a_drop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_drop_r) |-> out_busy_r)
    else $error("dropped push reported an idle transmitter");

endmodule

`default_nettype wire

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// testbench for uart_tx_fifo_serializer: push and bit-tick items checked against a line predictor
// depends on utx_pkg and the design sources of the block

module tb;
  import utx_pkg::*;

  localparam int FIFO_DEPTH  = 64;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_WAIT  = 8;

  typedef struct packed {
    logic tx_line;
    logic busy;
    logic dropped;
  } line_state_t;

  // block ports, all inputs known from time zero
  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = CFG_DATA_BITS;
  logic [CFG_DATA_W-1:0] cfg_wdata  = '0;
  logic                  in_valid   = 1'b0;
  logic                  in_stall;
  logic                  in_kind    = KIND_TICK;
  logic [7:0]            in_byte_in = '0;
  logic                  out_valid;
  logic                  out_stall  = 1'b0;
  logic                  out_tx_line;
  logic                  out_busy_res;
  logic                  out_dropped;

  uart_tx_fifo_serializer #(.FIFO_DEPTH(FIFO_DEPTH)) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_kind      (in_kind),
    .in_byte_in   (in_byte_in),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_tx_line  (out_tx_line),
    .out_busy_res (out_busy_res),
    .out_dropped  (out_dropped)
  );

  // predictor state: byte fifo, transmitter and current register values
  logic [7:0]  fifo_mem [FIFO_DEPTH];
  int unsigned rd_ptr    = 0;
  int unsigned wr_ptr    = 0;
  logic        tx_active = 1'b0;
  logic [7:0]  tx_pos    = 8'd0;
  logic [7:0]  tx_shift  = 8'd0;
  logic        tx_level  = 1'b1;
  logic [3:0]  data_bits = DATA_BITS_RST;
  logic [1:0]  stop_len  = STOP_LEN_RST;

  line_state_t expected_lines [$];

  int tx_idle_pct;
  int rx_idle_pct;
  int error_count     = 0;
  int items_sent      = 0;
  int results_checked = 0;
  int drops_seen      = 0;
  int chars_loaded    = 0;
  int settings_used   = 0;
  int cycle_count     = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int unsigned next_slot(int unsigned p);
    return (p + 1 >= FIFO_DEPTH) ? 0 : p + 1;
  endfunction

  // advance the predictor by one item and return the line state it leaves
  function automatic line_state_t predict_line(logic kind, logic [7:0] data);
    line_state_t r;
    int   pos;
    int   d;
    logic drop;
    drop = 1'b0;
    pos  = tx_pos;
    d    = data_bits;
    if (kind == KIND_PUSH) begin
      // one slot stays free; a rejected push still arms an idle transmitter
      if (rd_ptr != next_slot(wr_ptr)) begin
        fifo_mem[wr_ptr] = data;
        wr_ptr = next_slot(wr_ptr);
      end else begin
        drop = 1'b1;
        drops_seen++;
      end
      if (!tx_active) begin
        tx_active = 1'b1;
        tx_pos    = POS_LOAD;
      end
    end else if (tx_active) begin
      // line level for this bit time; the load phase keeps the level
      if (pos == 0) begin
        tx_level = 1'b0;
      end else if (pos >= d + 1 && pos <= d + 4) begin
        tx_level = 1'b1;
      end else if (pos != POS_LOAD) begin
        tx_level = (pos - 1 < 8) ? tx_shift[pos-1] : 1'b0;
      end
      // end of character: fetch the next byte or go idle
      if (pos > d + stop_len) begin
        if (rd_ptr != wr_ptr) begin
          tx_shift = fifo_mem[rd_ptr];
          rd_ptr   = next_slot(rd_ptr);
          chars_loaded++;
        end else begin
          tx_active = 1'b0;
        end
        tx_pos = 8'd0;
      end else begin
        tx_pos = 8'(pos + 1);
      end
    end
    r = '{tx_line: tx_level, busy: tx_active, dropped: drop};
    return r;
  endfunction

  function automatic void compare_field(string field, logic exp_v, logic act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %0b actual %0b", $time, field, exp_v, act_v);
      error_count++;
    end
  endfunction

  // result checker and receiver stall
  always @(posedge clk) begin
    line_state_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_lines.size() == 0) begin
        $display("%0t: result with nothing expected, actual tx_line=%0b busy=%0b dropped=%0b",
                 $time, out_tx_line, out_busy_res, out_dropped);
        error_count++;
      end else begin
        exp_r = expected_lines.pop_front();
        results_checked++;
        compare_field("tx_line", exp_r.tx_line, out_tx_line);
        compare_field("busy_res", exp_r.busy, out_busy_res);
        compare_field("dropped", exp_r.dropped, out_dropped);
      end
    end
    out_stall <= ($urandom_range(99) < rx_idle_pct);
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: run limit reached with %0d results outstanding",
               $time, expected_lines.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // send one item, wait for its handshake, then maybe idle the sender
  task automatic send_item(logic kind, logic [7:0] data);
    in_valid   <= 1'b1;
    in_kind    <= kind;
    in_byte_in <= data;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_lines.push_back(predict_line(kind, data));
    items_sent++;
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
  endtask

  task automatic send_ticks(int n);
    repeat (n) send_item(KIND_TICK, 8'($urandom));
  endtask

  // wait until every expected result has come back
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_lines.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // write both registers; the spare high bits of the stop length get random values
  task automatic write_config(logic [3:0] dbits, logic [1:0] sbits);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_DATA_BITS;
    cfg_wdata <= CFG_DATA_W'(dbits);
    @(posedge clk);
    cfg_index <= CFG_STOP_LEN;
    cfg_wdata <= CFG_DATA_W'({2'($urandom_range(3)), sbits});
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    data_bits = dbits;
    stop_len  = sbits;
    settings_used++;
  endtask

  // idle ticks, byte extremes, load phase and a full character at reset settings
  task automatic test_directed_basics();
    send_ticks(2);
    send_item(KIND_PUSH, 8'h00);
    send_item(KIND_PUSH, 8'hff);
    send_item(KIND_PUSH, 8'h5a);
    send_ticks(20);
    drain();
  endtask

  // fill the fifo past its limit so pushes get dropped
  task automatic test_fifo_full();
    send_item(KIND_PUSH, 8'haa);
    send_item(KIND_PUSH, 8'h55);
    repeat (68) send_item(KIND_PUSH, 8'($urandom));
    send_ticks(10);
    drain();
  endtask

  // odd register values, changed while a character is on the line
  task automatic test_odd_config();
    write_config(4'd15, 2'd0);
    send_ticks(40);
    drain();
    write_config(4'd0, 2'd2);
    send_ticks(20);
    drain();
    write_config(4'd0, 2'd0);
    send_ticks(15);
    drain();
    write_config(4'd5, 2'd3);
    send_ticks(25);
    drain();
  endtask

  // runs of push-heavy, mixed and tick-heavy traffic with random content
  task automatic test_random_traffic(int n_items);
    int push_pct;
    int run_len;
    int sent;
    sent = 0;
    while (sent < n_items) begin
      case ($urandom_range(2))
        0:       push_pct = 92;
        1:       push_pct = 45;
        default: push_pct = 8;
      endcase
      run_len = $urandom_range(12, 90);
      repeat (run_len) begin
        if ($urandom_range(99) < push_pct) send_item(KIND_PUSH, 8'($urandom));
        else send_item(KIND_TICK, 8'($urandom));
        sent++;
      end
    end
    drain();
  endtask

  // test sequence
  initial begin
    tx_idle_pct = 32;
    rx_idle_pct = 69;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_basics();
    test_fifo_full();
    test_odd_config();

    write_config(4'd5, 2'd1);
    test_random_traffic(520);

    tx_idle_pct = 69;
    rx_idle_pct = 32;
    write_config(4'd8, 2'd3);
    test_random_traffic(520);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_config(4'($urandom_range(5, 8)), 2'($urandom_range(1, 3)));
    test_random_traffic(520);

    $display("run covered %0d items over %0d register settings",
             items_sent, settings_used);
    $display("%0d characters loaded, %0d pushes dropped, %0d results compared, %0d mismatches",
             chars_loaded, drops_seen, results_checked, error_count);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
